[sv/set_assoc_tag_directory_plru_macros.svh]
// Assertion macros used by the tag directory back end.
// No dependencies; clock clk and reset rst must exist where used.
`ifndef SET_ASSOC_TAG_DIRECTORY_PLRU_MACROS_SVH
`define SET_ASSOC_TAG_DIRECTORY_PLRU_MACROS_SVH

// same-cycle implication
`define STAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/stad_pkg.sv]
// Shared types and constants of the tag directory.
// No dependencies.
`default_nettype none
package stad_pkg;
  localparam int SETS  = 128;
  localparam int SET_W = $clog2(SETS);
  localparam int WAYS  = 8;
  localparam int TAG_W = 32 - SET_W;

  localparam logic [2:0] REG_WAY_MODE = 3'd0;
  localparam logic [2:0] REG_OFFSET   = 3'd4;

  typedef struct packed {
    logic             wr;
    logic             eight;
    logic [2:0]       off;
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
  } req_t;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tags;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [6:0]                 plru;
  } row_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } qctl_t;
endpackage
`default_nettype wire

[sv/stad_front.sv]
// Front end: accepts requests, splits the address, holds them in a two-entry queue.
// Depends on stad_pkg.
`default_nettype none
module stad_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [39:0]  s_tdata,   // [0] operation, [32:1] address
  input  wire logic         way_mode,
  input  wire logic [2:0]   line_offset_bits,
  output stad_pkg::req_t    head,
  input  wire logic         pop,
  output logic              head_valid
);
  import stad_pkg::*;

  req_t       q [2];
  logic       wptr, rptr;
  logic [1:0] count;
  req_t       dec;
  logic [31:0] addr, tshift, sshift;
  logic       push;

  always_comb begin
    addr       = s_tdata[32:1];
    tshift     = addr >> ({1'b0, line_offset_bits} + 4'(SET_W));
    sshift     = addr >> line_offset_bits;
    dec.wr     = s_tdata[0];
    dec.eight  = way_mode;
    dec.off    = line_offset_bits;
    dec.set    = sshift[SET_W-1:0];
    dec.tag    = tshift[TAG_W-1:0];
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign head_valid = (count != 2'd0);
  assign head       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= dec;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop && head_valid) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop && head_valid);
    end
  end
endmodule
`default_nettype wire

[sv/stad_back.sv]
// Back end: reads a set row, resolves hit or victim, writes the row back, registers the result.
// Depends on stad_pkg and the macros header.
`default_nettype none
`include "set_assoc_tag_directory_plru_macros.svh"
module stad_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire stad_pkg::req_t  head,
  input  wire stad_pkg::qctl_t qctl_in,
  output logic                pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [39:0]         m_tdata   // [0] hit, [3:1] way, [4] writeback_needed,
                                        // [36:5] victim_line_address
);
  import stad_pkg::*;

  typedef enum logic {ST_IDLE, ST_EVAL} state_t;
  state_t state;

  row_t mem [SETS];
  row_t rdata, row, wrow;
  logic [SETS-1:0] row_valid;
  logic rv_q;
  req_t cur;

  logic [WAYS-1:0] act, match;
  logic hit, wb;
  logic [2:0] hway, victim, w, pick, inval_way;
  logic any_inval;
  logic [31:0] vaddr;
  logic fire;

  function automatic logic [6:0] touch(logic [6:0] p, logic eight, logic [2:0] w);
    logic [6:0] s, c;
    s = 7'd0;
    c = 7'd0;
    if (!eight) begin
      case (w[1:0])
        2'd0: s = 7'h03;
        2'd1: begin s = 7'h01; c = 7'h02; end
        2'd2: begin s = 7'h04; c = 7'h01; end
        default: c = 7'h05;
      endcase
    end else begin
      case (w)
        3'd0: s = 7'h0B;
        3'd1: begin s = 7'h03; c = 7'h08; end
        3'd2: begin s = 7'h11; c = 7'h02; end
        3'd3: begin s = 7'h01; c = 7'h12; end
        3'd4: begin s = 7'h24; c = 7'h01; end
        3'd5: begin s = 7'h04; c = 7'h21; end
        3'd6: begin s = 7'h40; c = 7'h05; end
        default: c = 7'h45;
      endcase
    end
    return (p | s) & ~c;
  endfunction

  function automatic logic [2:0] choose(logic [6:0] p, logic eight);
    logic [2:0] r;
    if (!eight) r = p[0] ? (p[2] ? 3'd3 : 3'd2) : (p[1] ? 3'd1 : 3'd0);
    else if (p[0]) r = p[2] ? (p[6] ? 3'd7 : 3'd6) : (p[5] ? 3'd5 : 3'd4);
    else r = p[1] ? (p[4] ? 3'd3 : 3'd2) : (p[3] ? 3'd1 : 3'd0);
    return r;
  endfunction

  assign pop  = (state == ST_IDLE) && qctl_in.valid;
  assign fire = (state == ST_EVAL) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (pop) rdata <= mem[head.set];
    if (fire) mem[cur.set] <= wrow;
  end

  always_comb begin
    row = rdata;
    if (!rv_q) begin
      row.valid = '0;
      row.dirty = '0;
      row.plru  = '0;
    end
    act = cur.eight ? 8'hFF : 8'h0F;
    for (int i = 0; i < WAYS; i++)
      match[i] = act[i] && row.valid[i] && (row.tags[i] == cur.tag);
    hit       = |match;
    hway      = '0;
    inval_way = '0;
    any_inval = 1'b0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) hway = 3'(i);
      if (act[i] && !row.valid[i]) begin
        inval_way = 3'(i);
        any_inval = 1'b1;
      end
    end
    pick   = choose(row.plru, cur.eight);
    victim = any_inval ? inval_way : pick;
    w      = hit ? hway : victim;
    wb     = !hit && row.valid[victim] && row.dirty[victim];
    vaddr  = wb ? ((32'(row.tags[victim]) << ({1'b0, cur.off} + 4'(SET_W)))
                   | (32'(cur.set) << cur.off)) : 32'd0;
    wrow = row;
    if (hit) begin
      wrow.plru = touch(row.plru, cur.eight, hway);
      if (cur.wr) wrow.dirty[hway] = 1'b1;
    end else begin
      wrow.tags[victim]  = cur.tag;
      wrow.valid[victim] = 1'b1;
      wrow.dirty[victim] = cur.wr;
      if (cur.wr) wrow.plru = touch(row.plru, cur.eight, victim);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (fire) m_tdata <= {3'b000, vaddr, wb, w, hit};
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      row_valid <= '0;
      rv_q      <= 1'b0;
    end else begin
      if (pop) rv_q <= row_valid[head.set];
      if (fire) row_valid[cur.set] <= 1'b1;
      if (fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (pop) state <= ST_EVAL;
        ST_EVAL: if (fire) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  `STAD_ASSERT_NEXT(a_fire_shows, fire, m_tvalid, "result not presented after evaluation")
  `STAD_ASSERT_NEXT(a_pop_evals, pop, state == ST_EVAL, "popped request not evaluated")
  `STAD_ASSERT_NOW(a_hit_no_wb, m_tvalid && m_tdata[0], !m_tdata[4], "writeback on a hit")
  `STAD_ASSERT_NOW(a_addr_zero, m_tvalid && !m_tdata[4], m_tdata[36:5] == 32'd0,
                   "victim address without writeback")
endmodule
`default_nettype wire

[sv/set_assoc_tag_directory_plru.sv]
// Path: a request is queued, popped with its set row read, then evaluated and written back.
// The back end takes one request at a time, set by the read-then-write of one set row.
// Reset: synchronous, active high; clears queue, row valid flags and output;
// way_mode returns to 1 and line_offset_bits to 5. Tag storage needs no clearing.
// Depends on stad_pkg, stad_front, stad_back.
`default_nettype none
module set_assoc_tag_directory_plru (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [0] operation, [32:1] address
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [0] hit, [3:1] way, [4] writeback_needed,
                                      // [36:5] victim_line_address
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import stad_pkg::*;

  logic       way_mode;
  logic [2:0] line_offset_bits;
  req_t       head;
  logic       head_valid, pop;
  qctl_t      qctl;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {29'd0, line_offset_bits} : {31'd0, way_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      way_mode         <= 1'b1;
      line_offset_bits <= 3'd5;
    end else if (psel && penable && pwrite && pready) begin
      if ({paddr[2], 2'b00} == REG_OFFSET) line_offset_bits <= pwdata[2:0];
      else if ({paddr[2], 2'b00} == REG_WAY_MODE) way_mode <= pwdata[0];
    end
  end

  assign qctl.valid = head_valid;
  assign qctl.pop   = pop;

  stad_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .way_mode, .line_offset_bits,
    .head, .pop(qctl.pop), .head_valid
  );

  stad_back u_back (
    .clk, .rst, .head, .qctl_in(qctl), .pop,
    .m_tvalid, .m_tready, .m_tdata
  );
endmodule
`default_nettype wire
